[rtl/smooth_vertex_normals_top_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the smooth vertex normal unit
// Each macro checks one implication on clk. The check is off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SMOOTH_VERTEX_NORMALS_TOP_MACROS_SVH
`define SMOOTH_VERTEX_NORMALS_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SVN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define SVN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define SVN_ASSERT_NOW(lbl, ante, cons, msg)
`define SVN_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[rtl/svn_pkg.sv]
// ---------------------------------------------------------------------------
// svn_pkg
// Commands, field widths and arithmetic widths for the vertex normal unit.
// ---------------------------------------------------------------------------
package svn_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_TRI  = 2'd1,
    CMD_READ = 2'd2
  } cmd_t;

  localparam int IDX_W  = 6;   // vertex index field
  localparam int POS_W  = 16;  // Q7.8 coordinate
  localparam int UNIT_W = 16;  // Q1.14 output component
  localparam int ACC_W  = 24;  // accumulator component
  localparam int EDGE_W = POS_W + 1;
  localparam int VEC_W  = 36;  // cross product / vector component
  localparam int MAG_W  = 36;
  localparam int MUL_W  = 32;
  localparam int LEN2_W = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 48;
  localparam int QUO_W  = 16;
  localparam int QI_W   = 4;

  localparam logic [QUO_W-1:0] UNIT_ONE = 16'd16384;

endpackage

[rtl/svn_isqrt.sv]
// ---------------------------------------------------------------------------
// svn_isqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ---------------------------------------------------------------------------
module svn_isqrt (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [svn_pkg::LEN2_W-1:0]      radicand,
  output logic                            done,
  output logic [svn_pkg::ROOT_W-1:0]      root
);

  localparam int W = svn_pkg::LEN2_W;

  logic         busy_r;
  logic         done_r;
  logic [W-1:0] v_r;
  logic [W-1:0] res_r;
  logic [W-1:0] bit_r;
  logic [W-1:0] trial;
  logic         ge;

  assign trial = res_r + bit_r;
  assign ge    = (v_r >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && bit_r[0];
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r   <= radicand;
      res_r <= '0;
      bit_r <= W'(1) << (W - 2);
    end else if (busy_r) begin
      if (ge) begin
        v_r   <= v_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign done = done_r;
  assign root = res_r[svn_pkg::ROOT_W-1:0];

endmodule

[rtl/smooth_vertex_normals_top.sv]
// ---------------------------------------------------------------------------
// smooth_vertex_normals_top
// Averaged vertex normals from face cross products, one shared multiplier.
// Input channel in_*: load vertex (position, clears its sum), add triangle,
// read vertex normal. Result channel out_*: one item per read command only.
// Triangles and reads take longer when more normalizing shifts are needed.
// Most of their time goes to the 32-step root unit and to three 16-step
// restoring divisions. in_ready is high only when the sequencer is idle. It
// takes one item at a time.
// The result register holds a read's normal until out_ready. The next item
// is taken meanwhile; a later read then waits in its output state.
// Reset clears the sequencer, the output valid flag and the accumulator
// valid bits, so every normal sum reads as zero. Positions are undefined
// until loaded. No clearing pass.
// ---------------------------------------------------------------------------
`include "smooth_vertex_normals_top_macros.svh"

module smooth_vertex_normals_top #(
  parameter int MAX_VERTICES = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_command,
  input  logic [svn_pkg::IDX_W-1:0]            in_vertex_index,
  input  logic signed [svn_pkg::POS_W-1:0]     in_pos_x,
  input  logic signed [svn_pkg::POS_W-1:0]     in_pos_y,
  input  logic signed [svn_pkg::POS_W-1:0]     in_pos_z,
  input  logic [svn_pkg::IDX_W-1:0]            in_corner_a,
  input  logic [svn_pkg::IDX_W-1:0]            in_corner_b,
  input  logic [svn_pkg::IDX_W-1:0]            in_corner_c,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [svn_pkg::UNIT_W-1:0]    out_normal_x,
  output logic signed [svn_pkg::UNIT_W-1:0]    out_normal_y,
  output logic signed [svn_pkg::UNIT_W-1:0]    out_normal_z,
  output logic                                 out_zero_normal
);

  localparam int IDX_W  = svn_pkg::IDX_W;
  localparam int POS_W  = svn_pkg::POS_W;
  localparam int UNIT_W = svn_pkg::UNIT_W;
  localparam int ACC_W  = svn_pkg::ACC_W;
  localparam int EDGE_W = svn_pkg::EDGE_W;
  localparam int VEC_W  = svn_pkg::VEC_W;
  localparam int MAG_W  = svn_pkg::MAG_W;
  localparam int MUL_W  = svn_pkg::MUL_W;
  localparam int LEN2_W = svn_pkg::LEN2_W;
  localparam int ROOT_W = svn_pkg::ROOT_W;
  localparam int REM_W  = svn_pkg::REM_W;
  localparam int QUO_W  = svn_pkg::QUO_W;
  localparam int QI_W   = svn_pkg::QI_W;

  // only indices the 6-bit fields can name need storage
  localparam int DEPTH = (MAX_VERTICES < (1 << IDX_W)) ? MAX_VERTICES : (1 << IDX_W);
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_POS    = 13'b0000000000010,
    S_CROSS  = 13'b0000000000100,
    S_NLOAD  = 13'b0000000001000,
    S_SCALE  = 13'b0000000010000,
    S_SQUARE = 13'b0000000100000,
    S_ROOT   = 13'b0000001000000,
    S_DSET   = 13'b0000010000000,
    S_DIV    = 13'b0000100000000,
    S_ACC_RD = 13'b0001000000000,
    S_ACC_WR = 13'b0010000000000,
    S_VLOAD  = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  function automatic logic idx_ok(input logic [IDX_W-1:0] idx);
    idx_ok = (32'(idx) < 32'(MAX_VERTICES));
  endfunction

  // storage
  logic [3*POS_W-1:0] pos_mem [DEPTH];
  logic [3*ACC_W-1:0] acc_mem [DEPTH];
  logic [DEPTH-1:0]   accv_r;

  // sequencer and datapath registers
  state_t                    state_r, state_nxt;
  logic                      out_valid_r;
  logic                      is_read_r;
  logic [AW-1:0]             corner_r [3];
  logic [AW-1:0]             vidx_r;
  logic [2:0]                cnt_r;
  logic [1:0]                jj_r;
  logic [QI_W-1:0]           qi_r;
  logic [3*POS_W-1:0]        pos_q_r, pa_r, pb_r, pc_r;
  logic [3*ACC_W-1:0]        acc_q_r;
  logic                      accv_q_r;
  logic signed [2*MUL_W-1:0] prod_r;
  logic signed [VEC_W-1:0]   vec_r [3];
  logic [2:0]                sign_r;
  logic [MAG_W-1:0]          mag_r [3];
  logic [LEN2_W-1:0]         len2_r;
  logic [ROOT_W-1:0]         root_r;
  logic [REM_W-1:0]          rem_r, div_r;
  logic [QUO_W-1:0]          quo_r;
  logic signed [UNIT_W-1:0]  nrm_r [3];
  logic                      zero_r;
  logic signed [UNIT_W-1:0]  out_nx_r, out_ny_r, out_nz_r;
  logic                      out_zero_r;

  // combinational
  logic                      in_acc, tri_ok, out_load;
  logic [AW-1:0]             in_addr, corner_sel, acc_raddr;
  logic signed [EDGE_W-1:0]  e1 [3];
  logic signed [EDGE_W-1:0]  e2 [3];
  logic signed [MUL_W-1:0]   mul_a, mul_b, cross_a, cross_b, sq_op;
  logic [MAG_W-1:0]          mx, mag_sel, mag_dsel;
  logic                      sign_dsel;
  logic [2:0]                cnt_m1;
  logic [LEN2_W-1:0]         len2_sum;
  logic                      sqrt_start, sqrt_done;
  logic [ROOT_W-1:0]         sqrt_root;
  logic                      div_ge;
  logic [QUO_W-1:0]          quo_fin, quo_clamp, quo_neg;
  logic [ACC_W:0]            acc_sum [3];
  logic [3*ACC_W-1:0]        acc_wdata;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign in_addr  = in_vertex_index[AW-1:0];
  assign tri_ok   = idx_ok(in_corner_a) && idx_ok(in_corner_b) && idx_ok(in_corner_c);
  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_ready);

  always_comb begin
    case (cnt_r)
      3'd0:    corner_sel = corner_r[0];
      3'd1:    corner_sel = corner_r[1];
      default: corner_sel = corner_r[2];
    endcase
  end
  assign acc_raddr = is_read_r ? vidx_r : corner_sel;

  // edges B-A and C-A
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1[i] = EDGE_W'($signed(pb_r[i*POS_W +: POS_W]))
            - EDGE_W'($signed(pa_r[i*POS_W +: POS_W]));
      e2[i] = EDGE_W'($signed(pc_r[i*POS_W +: POS_W]))
            - EDGE_W'($signed(pa_r[i*POS_W +: POS_W]));
    end
  end

  // operand select for the shared multiplier
  always_comb begin
    case (cnt_r)
      3'd0:    begin cross_a = MUL_W'(e1[1]); cross_b = MUL_W'(e2[2]); end
      3'd1:    begin cross_a = MUL_W'(e1[2]); cross_b = MUL_W'(e2[1]); end
      3'd2:    begin cross_a = MUL_W'(e1[2]); cross_b = MUL_W'(e2[0]); end
      3'd3:    begin cross_a = MUL_W'(e1[0]); cross_b = MUL_W'(e2[2]); end
      3'd4:    begin cross_a = MUL_W'(e1[0]); cross_b = MUL_W'(e2[1]); end
      default: begin cross_a = MUL_W'(e1[1]); cross_b = MUL_W'(e2[0]); end
    endcase
    case (cnt_r)
      3'd0:    mag_sel = mag_r[0];
      3'd1:    mag_sel = mag_r[1];
      default: mag_sel = mag_r[2];
    endcase
    sq_op = $signed({1'b0, mag_sel[MUL_W-2:0]});
    mul_a = (state_r == S_SQUARE) ? sq_op : cross_a;
    mul_b = (state_r == S_SQUARE) ? sq_op : cross_b;
  end

  assign cnt_m1   = cnt_r - 3'd1;
  assign len2_sum = len2_r + $unsigned(prod_r);

  always_comb begin
    mx = mag_r[0];
    if (mag_r[1] > mx) mx = mag_r[1];
    if (mag_r[2] > mx) mx = mag_r[2];
  end

  always_comb begin
    case (jj_r)
      2'd0:    begin mag_dsel = mag_r[0]; sign_dsel = sign_r[0]; end
      2'd1:    begin mag_dsel = mag_r[1]; sign_dsel = sign_r[1]; end
      default: begin mag_dsel = mag_r[2]; sign_dsel = sign_r[2]; end
    endcase
  end

  // restoring division step
  assign div_ge    = (rem_r >= div_r);
  assign quo_fin   = {quo_r[QUO_W-2:0], div_ge};
  assign quo_clamp = (quo_fin > svn_pkg::UNIT_ONE) ? svn_pkg::UNIT_ONE : quo_fin;
  assign quo_neg   = sign_dsel ? (~quo_clamp + QUO_W'(1)) : quo_clamp;

  // saturating accumulate; a sum never written reads as zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc_sum[i] = (accv_q_r ? {acc_q_r[i*ACC_W + ACC_W-1], acc_q_r[i*ACC_W +: ACC_W]}
                             : (ACC_W+1)'(0))
                 + (ACC_W+1)'(nrm_r[i]);
      if (acc_sum[i][ACC_W] != acc_sum[i][ACC_W-1]) begin
        acc_wdata[i*ACC_W +: ACC_W] = acc_sum[i][ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                                        : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
        acc_wdata[i*ACC_W +: ACC_W] = acc_sum[i][ACC_W-1:0];
      end
    end
  end

  assign sqrt_start = (state_r == S_SQUARE) && (cnt_r == 3'd3);

  svn_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (len2_sum),
    .done     (sqrt_done),
    .root     (sqrt_root)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            svn_pkg::CMD_TRI:  if (tri_ok) state_nxt = S_POS;
            svn_pkg::CMD_READ: state_nxt = idx_ok(in_vertex_index) ? S_ACC_RD : S_OUT;
            default: ;
          endcase
        end
      end
      S_POS:    if (cnt_r == 3'd3) state_nxt = S_CROSS;
      S_CROSS:  if (cnt_r == 3'd6) state_nxt = S_NLOAD;
      S_NLOAD:  state_nxt = S_SCALE;
      S_SCALE: begin
        if (mx == '0) begin
          state_nxt = is_read_r ? S_OUT : S_IDLE;
        end else if (mx[MAG_W-1:30] == '0) begin
          state_nxt = S_SCALE;
        end else if (mx[MAG_W-1:31] != '0) begin
          state_nxt = S_SCALE;
        end else begin
          state_nxt = S_SQUARE;
        end
      end
      S_SQUARE: if (cnt_r == 3'd3) state_nxt = S_ROOT;
      S_ROOT:   if (sqrt_done) state_nxt = S_DSET;
      S_DSET:   state_nxt = S_DIV;
      S_DIV: begin
        if (qi_r == '0) begin
          if (jj_r == 2'd2) state_nxt = is_read_r ? S_OUT : S_ACC_RD;
          else              state_nxt = S_DSET;
        end
      end
      S_ACC_RD: state_nxt = is_read_r ? S_VLOAD : S_ACC_WR;
      S_VLOAD:  state_nxt = S_NLOAD;
      S_ACC_WR: state_nxt = (cnt_r == 3'd2) ? S_IDLE : S_ACC_RD;
      S_OUT:    if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // accumulator valid bits: load clears, accumulate sets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accv_r <= '0;
    end else if (in_acc && (in_command == svn_pkg::CMD_LOAD) && idx_ok(in_vertex_index)) begin
      accv_r[in_addr] <= 1'b0;
    end else if (state_r == S_ACC_WR) begin
      accv_r[corner_sel] <= 1'b1;
    end
  end

  // memories, registered reads
  always_ff @(posedge clk) begin
    if (in_acc && (in_command == svn_pkg::CMD_LOAD) && idx_ok(in_vertex_index)) begin
      pos_mem[in_addr] <= {in_pos_z, in_pos_y, in_pos_x};
    end
    pos_q_r <= pos_mem[corner_sel];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_ACC_WR) begin
      acc_mem[corner_sel] <= acc_wdata;
    end
    acc_q_r  <= acc_mem[acc_raddr];
    accv_q_r <= accv_r[acc_raddr];
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          corner_r[0] <= in_corner_a[AW-1:0];
          corner_r[1] <= in_corner_b[AW-1:0];
          corner_r[2] <= in_corner_c[AW-1:0];
          vidx_r      <= in_addr;
          is_read_r   <= (in_command == svn_pkg::CMD_READ);
          cnt_r       <= '0;
          // out-of-range read answers zero with the flag set
          zero_r      <= 1'b1;
          for (int i = 0; i < 3; i++) nrm_r[i] <= '0;
        end
      end
      S_POS: begin
        if (cnt_r == 3'd3) cnt_r <= '0;
        else               cnt_r <= cnt_r + 3'd1;
        case (cnt_r)
          3'd1: pa_r <= pos_q_r;
          3'd2: pb_r <= pos_q_r;
          3'd3: begin
            pc_r <= pos_q_r;
            for (int i = 0; i < 3; i++) vec_r[i] <= '0;
          end
          default: ;
        endcase
      end
      S_CROSS: begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r != 3'd0) begin
          for (int i = 0; i < 3; i++) begin
            if (cnt_m1[2:1] == 2'(i)) begin
              vec_r[i] <= cnt_m1[0] ? vec_r[i] - $signed(prod_r[VEC_W-1:0])
                                    : vec_r[i] + $signed(prod_r[VEC_W-1:0]);
            end
          end
        end
      end
      S_VLOAD: begin
        for (int i = 0; i < 3; i++) begin
          vec_r[i] <= accv_q_r ? VEC_W'($signed(acc_q_r[i*ACC_W +: ACC_W])) : '0;
        end
      end
      S_NLOAD: begin
        for (int i = 0; i < 3; i++) begin
          sign_r[i] <= vec_r[i][VEC_W-1];
          mag_r[i]  <= vec_r[i][VEC_W-1] ? MAG_W'(-vec_r[i]) : MAG_W'(vec_r[i]);
        end
      end
      S_SCALE: begin
        // bring the largest magnitude into [2^30, 2^31)
        if (mx == '0) begin
          for (int i = 0; i < 3; i++) nrm_r[i] <= '0;
          zero_r <= 1'b1;
        end else if (mx[MAG_W-1:30] == '0) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] << 1;
        end else if (mx[MAG_W-1:31] != '0) begin
          for (int i = 0; i < 3; i++) mag_r[i] <= mag_r[i] >> 1;
        end else begin
          cnt_r  <= '0;
          len2_r <= '0;
        end
      end
      S_SQUARE: begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r != 3'd0) len2_r <= len2_sum;
      end
      S_ROOT: begin
        root_r <= sqrt_root;
        jj_r   <= '0;
      end
      S_DSET: begin
        rem_r <= REM_W'({mag_dsel[MUL_W-1:0], 14'b0}) + REM_W'(root_r >> 1);
        div_r <= REM_W'({root_r, {(QUO_W-1){1'b0}}});
        quo_r <= '0;
        qi_r  <= QI_W'(QUO_W - 1);
      end
      S_DIV: begin
        if (div_ge) rem_r <= rem_r - div_r;
        div_r <= div_r >> 1;
        quo_r <= quo_fin;
        qi_r  <= qi_r - QI_W'(1);
        if (qi_r == '0) begin
          for (int i = 0; i < 3; i++) begin
            if (jj_r == 2'(i)) nrm_r[i] <= $signed(quo_neg);
          end
          jj_r   <= jj_r + 2'd1;
          zero_r <= 1'b0;
          cnt_r  <= '0;
        end
      end
      S_ACC_WR: begin
        cnt_r <= cnt_r + 3'd1;
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_nx_r   <= nrm_r[0];
      out_ny_r   <= nrm_r[1];
      out_nz_r   <= nrm_r[2];
      out_zero_r <= zero_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_normal_x    = out_nx_r;
  assign out_normal_y    = out_ny_r;
  assign out_normal_z    = out_nz_r;
  assign out_zero_normal = out_zero_r;

  // only a read command leads to the output state
  `SVN_ASSERT_NEXT(a_result_only_on_read, in_acc && (in_command != svn_pkg::CMD_READ), state_r != S_OUT, "non-read item heading to output")
  // scaled magnitudes fit the squaring operand
  `SVN_ASSERT_NOW(a_scaled_mag, state_r == S_SQUARE, (mag_r[0][MAG_W-1:31] == '0) && (mag_r[1][MAG_W-1:31] == '0) && (mag_r[2][MAG_W-1:31] == '0), "magnitude above 2^31 at squaring")
  // length root is at least 2^30 once scaled
  `SVN_ASSERT_NOW(a_root_range, state_r == S_DSET, root_r[ROOT_W-1:ROOT_W-2] != 2'b00, "root below 2^30")
  // restoring division keeps the remainder below twice the shifted divisor
  `SVN_ASSERT_NOW(a_div_bound, state_r == S_DIV, rem_r < {div_r, 1'b0}, "division remainder out of range")

endmodule
